FILE: rtl/c8ook_pkg.sv
`default_nettype none

package c8ook_pkg;

	localparam logic [7:0] HEADER_BYTE  = 8'hAA;
	localparam logic [7:0] CRC_POLY     = 8'h31;
	localparam logic [7:0] CRC_TOP_BIT  = 8'h80;
	localparam int         FRAME_BITS   = 48;
	localparam logic [5:0] LAST_BIT_IDX = 6'd47;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// packed so that line_level sits in bit 0
	typedef struct packed {
		logic rejected;
		logic frame_done;
		logic busy_res;
		logic line_level;
	} c8ook_res_t;

	// bit-serial CRC-8, MSB first, init 0, no final xor; elaboration use only
	function automatic logic [7:0] crc8_msg(input logic [39:0] msg);
		logic [7:0] crc;
		logic       fb;
		crc = 8'h00;
		for (int k = 39; k >= 0; k--) begin
			fb  = ((crc & CRC_TOP_BIT) != 8'h00) ^ msg[k];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/c8ook_frame.sv
`default_nettype none

module c8ook_frame (
	input  wire logic [31:0] word,
	output logic      [47:0] frame
);

	// CRC is linear in the message: header term plus one column per payload bit
	localparam logic [7:0] HDR_CRC = c8ook_pkg::crc8_msg({c8ook_pkg::HEADER_BYTE, 32'h0});

	logic [7:0] col_term [32];
	logic [7:0] crc;

	genvar i;
	generate
		for (i = 0; i < 32; i++) begin : g_col
			localparam logic [7:0] COL = c8ook_pkg::crc8_msg({8'h00, 32'd1 << i});
			assign col_term[i] = word[i] ? COL : 8'h00;
		end
	endgenerate

	always_comb begin
		crc = HDR_CRC;
		for (int k = 0; k < 32; k++) begin
			crc = crc ^ col_term[k];
		end
	end

	assign frame = {c8ook_pkg::HEADER_BYTE, word, crc};

endmodule

`default_nettype wire

FILE: rtl/c8ook_obuf.sv
`default_nettype none

module c8ook_obuf (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire c8ook_pkg::c8ook_res_t  wr_data,
	output logic                        space,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [7:0]                  m_tdata
);

	c8ook_pkg::c8ook_res_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       rd_en;

	assign m_tvalid = (count_q != 2'd0);
	assign rd_en    = m_tvalid && m_tready;
	assign space    = (count_q != 2'd2) || m_tready;
	assign m_tdata  = {4'b0000, ent_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q != 2'd2) || m_tready)
		else $error("result written into a full buffer");
`endif

endmodule

`default_nettype wire

FILE: rtl/c8ook_core.sv
`default_nettype none

module c8ook_core #(
	parameter int PERIOD_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [31:0]            s_tdata,
	input  wire logic                   s_action,
	input  wire logic                   cfg_wr_en,
	input  wire logic [15:0]            cfg_wr_data,
	input  wire logic                   space,
	output logic                        res_valid,
	output c8ook_pkg::c8ook_res_t       res
);

	localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(1000);

	logic                    valid_s1;
	logic                    action_s1;
	logic [31:0]             word_s1;
	logic                    adv;

	logic [PERIOD_WIDTH-1:0] period_q;
	logic [47:0]             frame_q;
	logic [5:0]              bit_idx_q;
	logic [PERIOD_WIDTH-1:0] tick_q;
	logic                    sending_q;

	logic [47:0]             frame_new;
	logic [47:0]             frame_d;
	logic [5:0]              bit_idx_d;
	logic [PERIOD_WIDTH-1:0] tick_d;
	logic                    sending_d;
	logic [PERIOD_WIDTH-1:0] tick_inc;
	logic                    bit_end;

	c8ook_frame u_frame (
		.word  (word_s1),
		.frame (frame_new)
	);

	assign adv       = valid_s1 && space;
	assign s_tready  = !valid_s1 || adv;
	assign res_valid = adv;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1   <= s_tdata;
			action_s1 <= s_action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		frame_d   = frame_q;
		bit_idx_d = bit_idx_q;
		tick_d    = tick_q;
		sending_d = sending_q;
		res       = '0;
		tick_inc  = tick_q + PERIOD_WIDTH'(1);
		bit_end   = (tick_inc >= period_q) || (tick_inc == '0);

		if (action_s1 == c8ook_pkg::ACT_LOAD) begin
			if (sending_q) begin
				res.rejected   = 1'b1;
				res.line_level = frame_q[47];
			end else begin
				frame_d        = frame_new;
				bit_idx_d      = 6'd0;
				tick_d         = '0;
				sending_d      = 1'b1;
				res.line_level = frame_new[47];
			end
		end else if (sending_q) begin
			res.line_level = frame_q[47];
			if (bit_end) begin
				tick_d  = '0;
				frame_d = {frame_q[46:0], 1'b0};
				if (bit_idx_q == c8ook_pkg::LAST_BIT_IDX) begin
					bit_idx_d      = 6'd0;
					sending_d      = 1'b0;
					res.frame_done = 1'b1;
				end else begin
					bit_idx_d = bit_idx_q + 6'd1;
				end
			end else begin
				tick_d = tick_inc;
			end
		end
		res.busy_res = sending_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_q <= frame_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			bit_idx_q <= 6'd0;
			tick_q    <= '0;
			sending_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				period_q <= PERIOD_WIDTH'(cfg_wr_data);
			end
			if (adv) begin
				bit_idx_q <= bit_idx_d;
				tick_q    <= tick_d;
				sending_q <= sending_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q |-> bit_idx_q <= c8ook_pkg::LAST_BIT_IDX)
		else $error("bit index beyond frame");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (bit_idx_q == 6'd0) && (tick_q == '0))
		else $error("counters not cleared while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.frame_done |=> !sending_q)
		else $error("still sending after frame end");
`endif

endmodule

`default_nettype wire

FILE: rtl/crc8_framed_ook_bit_transmitter.sv
// channel  | signals                      | payload
// s_       | tvalid tready tdata tuser    | tdata payload_word[31:0], tuser action
// m_       | tvalid tready tdata          | tdata line_level, busy_res, frame_done, rejected
// cfg_     | wr_en wr_data                | bit_period_ticks[15:0]
//
// One transaction per cycle in each direction while m_tready stays high.
// Path: input register, CRC/bit update logic, two-entry result buffer.
// arst_n clears the control state; period returns to 1000 ticks.
// Output stall fills the buffer and then the input register, then input tready drops.
`default_nettype none

module crc8_framed_ook_bit_transmitter #(
	parameter int PERIOD_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // payload_word
	input  wire logic [0:0]  s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // line_level, busy_res, frame_done, rejected, zero pad
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	c8ook_pkg::c8ook_res_t res;
	logic                  res_valid;
	logic                  space;

	c8ook_core #(
		.PERIOD_WIDTH (PERIOD_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_action    (s_tuser[0]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.space       (space),
		.res_valid   (res_valid),
		.res         (res)
	);

	c8ook_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
